FILE: rtl/stack_with_duplicate_removal_defines.svh
// Assertion macros shared by the stack checker
`ifndef STACK_WITH_DUPLICATE_REMOVAL_DEFINES_SVH
`define STACK_WITH_DUPLICATE_REMOVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWDR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stack port check failed");

// next-cycle implication, sampled on clk, off during reset
`define SWDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stack port check failed");

`endif

FILE: rtl/swdr_pkg.sv
// Types and constants for the LIFO stack with duplicate removal
`timescale 1ns / 1ps

package swdr_pkg;

	localparam int REQ_W  = 2;
	localparam int POP_W  = 32;
	localparam int STAT_W = 2;
	localparam int DOUT_W = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_DEDUP = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		DD_IDLE,
		DD_LOADV,
		DD_SCAN
	} dd_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dd_ctl_t;

endpackage

FILE: rtl/swdr_mem.sv
// Stack storage: one write port, one read port, registered read data
`timescale 1ns / 1ps

module swdr_mem #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/swdr_dedup.sv
// Duplicate-removal sequencer: in-place compaction over the stack memory
`timescale 1ns / 1ps

module swdr_dedup #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CW-1:0]         cnt,
	input  logic [DATA_WIDTH-1:0] rdata,
	output logic                  re,
	output logic [AW-1:0]         raddr,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output logic [DATA_WIDTH-1:0] wdata,
	output logic [CW-1:0]         kept,
	output swdr_pkg::dd_ctl_t     ctl
);

	import swdr_pkg::*;

	// Entry i survives when no equal word sits above it. Survivors are copied
	// down to the write pointer, which never passes i, so unread entries stay.
	dd_state_t             state_q, state_d;
	logic [CW-1:0]         i_q, i_d;
	logic [CW-1:0]         j_q, j_d;
	logic [CW-1:0]         w_q, w_d;
	logic [CW-1:0]         n_q, n_d;
	logic [DATA_WIDTH-1:0] v_q, v_d;
	logic [CW-1:0]         i_nx;
	logic                  dup;

	assign i_nx = i_q + CW'(1);
	assign dup  = (rdata == v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		w_q <= w_d;
		n_q <= n_d;
		v_q <= v_d;
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		w_d      = w_q;
		n_d      = n_q;
		v_d      = v_q;
		re       = 1'b0;
		raddr    = i_nx[AW-1:0];
		we       = 1'b0;
		waddr    = w_q[AW-1:0];
		wdata    = v_q;
		ctl.done = 1'b0;
		ctl.busy = (state_q != DD_IDLE);
		case (state_q)
			DD_IDLE: begin
				if (start) begin
					re      = 1'b1;
					raddr   = '0;
					i_d     = '0;
					w_d     = '0;
					n_d     = cnt;
					state_d = DD_LOADV;
				end
			end
			DD_LOADV: begin
				v_d = rdata;
				if (i_nx == n_q) begin
					// topmost entry always survives and ends the pass
					we       = 1'b1;
					wdata    = rdata;
					w_d      = w_q + CW'(1);
					ctl.done = 1'b1;
					state_d  = DD_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = i_nx[AW-1:0];
					j_d     = i_q + CW'(2);
					state_d = DD_SCAN;
				end
			end
			DD_SCAN: begin
				if (dup || (j_q == n_q)) begin
					if (!dup) begin
						we  = 1'b1;
						w_d = w_q + CW'(1);
					end
					re      = 1'b1;
					raddr   = i_nx[AW-1:0];
					i_d     = i_nx;
					state_d = DD_LOADV;
				end else begin
					re    = 1'b1;
					raddr = j_q[AW-1:0];
					j_d   = j_q + CW'(1);
				end
			end
			default: begin
				state_d = DD_IDLE;
			end
		endcase
	end

	assign kept = w_q + CW'(1);

endmodule

FILE: rtl/stack_with_duplicate_removal.sv
// Top level: bounded LIFO stack of signed words with duplicate removal
// The result passes through the s1 register and then the output register after the input transfer.
// Push, pop and unknown requests can be accepted back to back unless the output stalls or a walk runs.
// Remove-duplicates on n entries holds the input stalled until the walk ends: the
// compaction walk issues one memory read per cycle.
// Reset clears the fill count and the valid flags; stack memory contents are not reset.
`timescale 1ns / 1ps

module stack_with_duplicate_removal #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [swdr_pkg::REQ_W-1:0]    req_type,
	input  logic signed [swdr_pkg::POP_W-1:0] push_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [swdr_pkg::POP_W-1:0] pop_value,
	output logic [swdr_pkg::STAT_W-1:0]   status,
	output logic [swdr_pkg::DOUT_W-1:0]   depth_after
);

	import swdr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         fill_q, fill_d, fill_m1;
	logic                  acc, out_free;

	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, rd_data;

	logic                  dd_start, dd_re, dd_we;
	logic [AW-1:0]         dd_raddr, dd_waddr;
	logic [DATA_WIDTH-1:0] dd_wdata;
	logic [CW-1:0]         dd_kept;
	dd_ctl_t               dd_ctl;

	logic                  nx_vld, nx_pop;
	stat_t                 nx_stat;

	logic                  vld_s1, pop_s1;
	stat_t                 status_s1;
	logic [DOUT_W-1:0]     depth_s1;

	logic                  out_vld_q;
	logic [POP_W-1:0]      pop_value_q;
	stat_t                 status_q;
	logic [DOUT_W-1:0]     depth_q;

	assign out_free = !out_vld_q || !out_stall;
	assign in_stall = dd_ctl.busy || (vld_s1 && !out_free);
	assign acc      = in_valid && !in_stall;
	assign fill_m1  = fill_q - CW'(1);

	swdr_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	swdr_dedup #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dedup (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dd_start),
		.cnt    (fill_q),
		.rdata  (rd_data),
		.re     (dd_re),
		.raddr  (dd_raddr),
		.we     (dd_we),
		.waddr  (dd_waddr),
		.wdata  (dd_wdata),
		.kept   (dd_kept),
		.ctl    (dd_ctl)
	);

	// request decode; the dedup walk owns the memory while it runs
	always_comb begin
		mem_we    = dd_we;
		mem_waddr = dd_waddr;
		mem_wdata = dd_wdata;
		mem_re    = dd_re;
		mem_raddr = dd_raddr;
		dd_start  = 1'b0;
		fill_d    = fill_q;
		nx_vld    = 1'b0;
		nx_pop    = 1'b0;
		nx_stat   = ST_OK;
		if (acc) begin
			nx_vld = 1'b1;
			case (req_type)
				REQ_PUSH: begin
					if (fill_q == CW'(DEPTH)) begin
						nx_stat = ST_OVER;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = fill_q[AW-1:0];
						mem_wdata = DATA_WIDTH'(push_value);
						fill_d    = fill_q + CW'(1);
					end
				end
				REQ_POP: begin
					if (fill_q == '0) begin
						nx_stat = ST_UNDER;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = fill_m1[AW-1:0];
						fill_d    = fill_m1;
						nx_pop    = 1'b1;
					end
				end
				REQ_DEDUP: begin
					// with two or more entries the result comes back when the walk ends
					if (fill_q >= CW'(2)) begin
						dd_start = 1'b1;
						nx_vld   = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end else if (dd_ctl.done) begin
			nx_vld = 1'b1;
			fill_d = dd_kept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (acc || dd_ctl.done) begin
				vld_s1 <= nx_vld;
			end else if (out_free) begin
				vld_s1 <= 1'b0;
			end
			if (out_free) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc || dd_ctl.done) begin
			pop_s1    <= nx_pop;
			status_s1 <= nx_stat;
			depth_s1  <= DOUT_W'(fill_d);
		end
		// pop data arrives from the memory while the request sits in s1
		if (out_free && vld_s1) begin
			pop_value_q <= pop_s1 ? POP_W'(signed'(rd_data)) : '0;
			status_q    <= status_s1;
			depth_q     <= depth_s1;
		end
	end

	assign out_valid   = out_vld_q;
	assign pop_value   = pop_value_q;
	assign status      = status_q;
	assign depth_after = depth_q;

endmodule

FILE: rtl/swdr_chk.sv
// Port checker for the stack, bound to the top level
`timescale 1ns / 1ps
`include "stack_with_duplicate_removal_defines.svh"

module swdr_chk #(
	parameter int DEPTH = 64
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [swdr_pkg::POP_W-1:0] pop_value,
	input logic [swdr_pkg::STAT_W-1:0]       status,
	input logic [swdr_pkg::DOUT_W-1:0]       depth_after
);

	import swdr_pkg::*;

	`SWDR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pop_value) && $stable(status) && $stable(depth_after))
	`SWDR_ASSERT_NOW(a_under_empty, out_valid && (status == ST_UNDER), (pop_value == '0) && (depth_after == '0))
	`SWDR_ASSERT_NOW(a_over_full, out_valid && (status == ST_OVER), (pop_value == '0) && (depth_after == DOUT_W'(DEPTH)))
	`SWDR_ASSERT_NOW(a_value_ok, out_valid && (pop_value != '0), status == ST_OK)

endmodule

bind stack_with_duplicate_removal swdr_chk #(
	.DEPTH (DEPTH)
) u_swdr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pop_value   (pop_value),
	.status      (status),
	.depth_after (depth_after)
);
